FILE: rtl/qcpg_pkg.sv
// Shared constants, types and lookup functions of the quasicrystal pattern generator.
`timescale 1ns / 1ps

package qcpg_pkg;

  localparam int NUM_WAVES = 7;
  localparam logic [7:0] SPEED_RESET = 8'd12;
  localparam int SUM_W = 10;  // |sum| <= 7*60 = 420

  typedef logic [15:0] phase_t;
  typedef logic signed [7:0] cos_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [NUM_WAVES-1:0][15:0] phase_vec_t;

  // Plane-wave directions, Q8, two's complement; entries 7 to 15 are zero
  localparam logic [15:0] DIR_X [16] = '{
    16'd153, 16'd95, -16'sd34, -16'sd138, -16'sd138, -16'sd34, 16'd95,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };
  localparam logic [15:0] DIR_Y [16] = '{
    16'd0, 16'd120, 16'd149, 16'd66, -16'sd66, -16'sd149, -16'sd120,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  // Quarter wave of trunc(60*cos(2*pi*i/256)), i = 0..64
  localparam logic [5:0] QUARTER_COS [65] = '{
    6'd60, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59,
    6'd58, 6'd58, 6'd58, 6'd57, 6'd57, 6'd56, 6'd56, 6'd55,
    6'd55, 6'd54, 6'd54, 6'd53, 6'd52, 6'd52, 6'd51, 6'd50,
    6'd49, 6'd49, 6'd48, 6'd47, 6'd46, 6'd45, 6'd44, 6'd43,
    6'd42, 6'd41, 6'd40, 6'd39, 6'd38, 6'd36, 6'd35, 6'd34,
    6'd33, 6'd32, 6'd30, 6'd29, 6'd28, 6'd26, 6'd25, 6'd24,
    6'd22, 6'd21, 6'd20, 6'd18, 6'd17, 6'd16, 6'd14, 6'd13,
    6'd11, 6'd10, 6'd8, 6'd7, 6'd5, 6'd4, 6'd2, 6'd1,
    6'd0
  };

  // Full-period cosine from the quarter table
  function automatic cos_t cos_lookup(input logic [7:0] idx);
    logic [7:0] pos;
    logic       neg;
    cos_t       mag;
    pos = idx;
    neg = 1'b0;
    if (idx <= 8'd64) begin
      pos = idx;
    end else if (idx <= 8'd128) begin
      pos = 8'd128 - idx;
      neg = 1'b1;
    end else if (idx <= 8'd192) begin
      pos = idx - 8'd128;
      neg = 1'b1;
    end else begin
      pos = 8'd0 - idx;
    end
    mag = cos_t'({2'b00, QUARTER_COS[pos[6:0]]});
    return neg ? -mag : mag;
  endfunction

  // Black-gold-cyan palette packed as RGB565
  function automatic logic [15:0] palette(input logic [7:0] i);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [8:0] b_wide;
    r = '0;
    g = '0;
    b = '0;
    b_wide = '0;
    if (!i[7]) begin
      r = {i[6:0], 1'b0};
      g = i;
      b = {2'b00, i[7:2]};
    end else begin
      r = 8'd255 - {1'b0, i[6:0]};
      g = 8'd128 + {1'b0, i[6:0]};
      b_wide = 9'd32 + {1'b0, i[6:0], 1'b0};
      b = b_wide[8] ? 8'd255 : b_wide[7:0];
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: rtl/qcpg_wave_sum.sv
// Per-wave phase completion, cosine lookup and signed sum of all waves.
`timescale 1ns / 1ps

module qcpg_wave_sum
  import qcpg_pkg::*;
(
  input  phase_t     base,
  input  phase_vec_t pxy,
  output sum_t       sum
);

  phase_t phase [NUM_WAVES];
  cos_t   cos_val [NUM_WAVES];

  // Finish each phase with the time term scaled by the wave number, then look up
  always_comb begin
    for (int k = 0; k < NUM_WAVES; k++) begin
      phase[k]   = 16'(base * 16'(k + 1)) + pxy[k];
      cos_val[k] = cos_lookup(phase[k][15:8]);
    end
  end

  // Add the wave values
  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_WAVES; k++) begin
      sum = sum + SUM_W'(cos_val[k]);
    end
  end

endmodule

FILE: rtl/quasicrystal_pattern_generator.sv
// Top level: four-register pipeline producing one RGB565 pixel per request.
// The request is captured in stage 1, then moves through stages 2 and 3 to the output register.
// Throughput: one request per cycle unless the output stalls; each stage holds while the next one is full
// and stalled, so a stall on the output ripples back to in_ready in the same cycle.
// Reset: rst (synchronous) empties the pipeline and sets phase_speed to 12.
`timescale 1ns / 1ps

module quasicrystal_pattern_generator
  import qcpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] frame_tick,
  input  logic [8:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  intensity,
  output logic [15:0] pixel_rgb565
);

  logic [7:0]  phase_speed;
  logic        v1, v2, v3;
  logic        load1, load2, load3, load4;
  logic [15:0] tick1;
  logic [8:0]  px1;
  logic [7:0]  py1;
  phase_t      base2;
  phase_t      base_next;
  phase_vec_t  pxy2;
  phase_vec_t  pxy_next;
  sum_t        sum3;
  sum_t        sum_next;
  logic [9:0]  mag;
  logic [7:0]  intensity_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_speed <= SPEED_RESET;
    end else if (cfg_wr_en) begin
      phase_speed <= cfg_wr_data;
    end
  end

  // Stage enables: a stage loads when empty or when its content moves on
  assign load4    = !out_valid || out_ready;
  assign load3    = !v3 || load4;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign in_ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1) v1 <= in_valid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) out_valid <= v3;
    end
  end

  // Stage 1: capture the request
  always_ff @(posedge clk) begin
    if (load1) begin
      tick1 <= frame_tick;
      px1   <= pixel_x;
      py1   <= pixel_y;
    end
  end

  // Stage 2: time base and spatial phase of each wave
  always_comb begin
    base_next = 16'(tick1 * {8'd0, phase_speed});
    for (int k = 0; k < NUM_WAVES; k++) begin
      pxy_next[k] = 16'({7'd0, px1} * DIR_X[k & 15]) + 16'({8'd0, py1} * DIR_Y[k & 15]);
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      base2 <= base_next;
      pxy2  <= pxy_next;
    end
  end

  // Stage 3: wave sum
  qcpg_wave_sum u_wave_sum (
    .base (base2),
    .pxy  (pxy2),
    .sum  (sum_next)
  );

  always_ff @(posedge clk) begin
    if (load3) begin
      sum3 <= sum_next;
    end
  end

  // Stage 4: magnitude, saturate and color
  assign mag            = sum3[SUM_W-1] ? 10'(-sum3) : 10'(sum3);
  assign intensity_next = (mag > 10'd255) ? 8'd255 : mag[7:0];

  always_ff @(posedge clk) begin
    if (load4) begin
      intensity    <= intensity_next;
      pixel_rgb565 <= palette(intensity_next);
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("pipeline not empty after reset");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (sum3 <= 10'sd420) && (sum3 >= -10'sd420))
    else $error("wave sum out of range");

  a_color_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_rgb565 == palette(intensity))
    else $error("color does not match intensity");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the quasicrystal pattern generator.
`timescale 1ns / 1ps

module testbench;
  import qcpg_pkg::*;

  typedef struct packed {
    logic [7:0]  intensity;
    logic [15:0] rgb;
  } pixel_t;

  // Quarter cosine wave, trunc(60*cos(2*pi*i/256)) for i = 0..64
  localparam int QCOS [65] = '{
    60, 59, 59, 59, 59, 59, 59, 59, 58, 58, 58, 57, 57, 56, 56, 55,
    55, 54, 54, 53, 52, 52, 51, 50, 49, 49, 48, 47, 46, 45, 44, 43,
    42, 41, 40, 39, 38, 36, 35, 34, 33, 32, 30, 29, 28, 26, 25, 24,
    22, 21, 20, 18, 17, 16, 14, 13, 11, 10, 8, 7, 5, 4, 2, 1,
    0
  };
  localparam int PLANE_WAVES = 7;
  localparam int WAVE_DX [PLANE_WAVES] = '{153, 95, -34, -138, -138, -34, 95};
  localparam int WAVE_DY [PLANE_WAVES] = '{0, 120, 149, 66, -66, -149, -120};
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] frame_tick = '0;
  logic [8:0]  pixel_x = '0;
  logic [7:0]  pixel_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  intensity;
  logic [15:0] pixel_rgb565;

  pixel_t     expected_pixels [$];
  logic [7:0] cur_speed = SPEED_RESET;
  bit         sender_idle = 1'b1;
  bit         receiver_idle = 1'b1;
  int         stall_cycles = 0;
  int         error_count = 0;
  int         request_count = 0;
  int         pixel_count = 0;
  int         saturated_count = 0;

  quasicrystal_pattern_generator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_tick  (frame_tick),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .intensity   (intensity),
    .pixel_rgb565(pixel_rgb565)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Full-period cosine built from the quarter wave
  function automatic int cos_sample(input int idx);
    if (idx <= 64) begin
      return QCOS[idx];
    end else if (idx <= 128) begin
      return -QCOS[128 - idx];
    end else if (idx <= 192) begin
      return -QCOS[idx - 128];
    end
    return QCOS[256 - idx];
  endfunction

  // Sum the seven plane waves, saturate the magnitude and look up the color
  function automatic pixel_t predict_pixel(input logic [15:0] tick, input logic [8:0] px,
                                           input logic [7:0] py, input logic [7:0] speed);
    int     base;
    int     ph;
    int     acc;
    int     mag;
    int     v;
    int     r;
    int     g;
    int     b;
    pixel_t res;
    base = (int'(tick) * int'(speed)) & 'hFFFF;
    acc = 0;
    for (int k = 0; k < PLANE_WAVES; k++) begin
      ph = base * (k + 1) + int'(px) * WAVE_DX[k] + int'(py) * WAVE_DY[k];
      acc += cos_sample((ph >> 8) & 255);
    end
    mag = (acc < 0) ? -acc : acc;
    if (mag > 255) mag = 255;
    if (mag < 128) begin
      r = 2 * mag;
      g = mag;
      b = mag / 4;
    end else begin
      v = mag - 128;
      r = 255 - v;
      g = 128 + v;
      b = 32 + 2 * v;
      if (b > 255) b = 255;
    end
    res.intensity = 8'(mag);
    res.rgb = 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
    return res;
  endfunction

  // Offer one request, hold it until accepted, then queue its pixel
  task automatic send_request(input logic [15:0] tick, input logic [8:0] px,
                              input logic [7:0] py);
    if (sender_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_tick <= tick;
    pixel_x    <= px;
    pixel_y    <= py;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(predict_pixel(tick, px, py, cur_speed));
    request_count++;
  endtask

  // Drop valid and wait for every queued pixel to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Write the phase speed while the pipeline is empty
  task automatic write_speed(input logic [7:0] speed);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= speed;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_speed = speed;
  endtask

  task automatic apply_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // Field extremes, frame edges, out-of-frame pixels, wraps and speed extremes
  task automatic test_directed();
    send_request(16'd0, 9'd0, 8'd0);          // all waves in phase: saturated
    send_request(16'hFFFF, 9'd511, 8'd255);
    send_request(16'hFFFF, 9'd0, 8'd0);
    send_request(16'd0, 9'd319, 8'd239);
    send_request(16'd0, 9'd320, 8'd0);        // past the right edge
    send_request(16'd0, 9'd0, 8'd240);        // below the last row
    send_request(16'd0, 9'd511, 8'd0);
    send_request(16'd0, 9'd0, 8'd255);
    send_request(16'd1, 9'd1, 8'd1);
    send_request(16'h8000, 9'd0, 8'd0);
    send_request(16'h5555, 9'h155, 8'hAA);
    send_request(16'hAAAA, 9'h0AA, 8'h55);
    write_speed(8'd255);
    send_request(16'hFFFF, 9'd319, 8'd239);
    send_request(16'hFFFF, 9'd511, 8'd255);
    send_request(16'd257, 9'd0, 8'd0);
    send_request(16'd0, 9'd0, 8'd0);
    write_speed(8'd0);
    send_request(16'hFFFF, 9'd100, 8'd100);
    send_request(16'd0, 9'd319, 8'd239);
    send_request(16'h1234, 9'd511, 8'd255);
    write_speed(8'd1);
    send_request(16'hFFFF, 9'd160, 8'd120);
    send_request(16'h00FF, 9'd0, 8'd239);
  endtask

  // Raster runs along rows mixed with scattered pixels, across several speeds
  task automatic test_random_frames();
    logic [15:0] tick;
    logic [8:0]  px;
    logic [7:0]  py;
    logic [7:0]  speed;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: speed = SPEED_RESET;
        1: speed = 8'd255;
        2: speed = 8'd0;
        default: speed = 8'($urandom_range(1, 254));
      endcase
      write_speed(speed);
      // leave one phase with no idling on either side
      sender_idle   = (p != 3);
      receiver_idle = (p != 3);
      tick = 16'($urandom);
      px = '0;
      py = 8'($urandom_range(0, 239));
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(99) < 55 && px < 9'd319) begin
          px = px + 9'd1;
        end else if ($urandom_range(99) < 80) begin
          tick = ($urandom_range(99) < 50) ? tick + 16'd1 : 16'($urandom);
          px = 9'($urandom_range(0, 319));
          py = 8'($urandom_range(0, 239));
        end else begin
          tick = 16'($urandom);
          px = 9'($urandom_range(0, 511));
          py = 8'($urandom_range(0, 255));
        end
        send_request(tick, px, py);
      end
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Hold off the output for a long stretch while requests keep coming
  task automatic test_output_stall();
    write_speed(8'($urandom_range(1, 254)));
    sender_idle = 1'b0;
    stall_cycles = 120;
    for (int i = 0; i < 80; i++) begin
      send_request(16'($urandom), 9'($urandom_range(0, 511)), 8'($urandom));
    end
    sender_idle = 1'b1;
  endtask

  // Drive output ready: long hold-off when asked, else random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        out_ready <= 1'b0;
        stall_cycles--;
      end else if (receiver_idle) begin
        out_ready <= ($urandom_range(99) >= 31);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each delivered pixel with the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with no request pending: intensity %0d rgb %h", intensity, pixel_rgb565);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        pixel_count++;
        if (want.intensity == 8'd255) saturated_count++;
        if (intensity !== want.intensity) begin
          $error("intensity: expected %0d, got %0d", want.intensity, intensity);
          error_count++;
        end
        if (pixel_rgb565 !== want.rgb) begin
          $error("pixel_rgb565: expected %h, got %h", want.rgb, pixel_rgb565);
          error_count++;
        end
      end
    end
  end

  initial begin
    apply_reset();
    test_directed();
    test_random_frames();
    test_output_stall();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d requests, %0d pixels checked (%0d saturated), %0d mismatches",
             request_count, pixel_count, saturated_count, error_count);
    $display("summary: phase speeds 0, 1, 12, 255 and random; frame edges and beyond");
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
